// File: rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared widths, operation and status codes for the byte ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

	localparam int unsigned OP_W    = 3;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEN_W   = 7;
	localparam int unsigned OFS_W   = 12;
	localparam int unsigned ST_W    = 2;
	localparam int unsigned FILL_W  = 13;
	localparam int unsigned CAP_W   = 13;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam int unsigned DEPTH_DEF     = 4096;
	localparam int unsigned MAX_BURST_DEF = 64;

	localparam logic [CAP_W-1:0] CAP_RST = 13'd4096;

	// register index, taken from paddr[2]
	localparam logic [0:0] REG_CAPACITY = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 3'd0,
		OP_READ  = 3'd1,
		OP_PEEK  = 3'd2,
		OP_GET   = 3'd3,
		OP_CLEAR = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_DATA = 2'd0,
		ST_ACK  = 2'd1,
		ST_REJ  = 2'd2
	} st_t;

endpackage

`default_nettype wire

// File: rtl/brb_if.sv
// ----------------------------------------------------------------------------
// brb request / response channels
// Valid-ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface brb_req_if;
	import brb_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [BYTE_W-1:0]   data_byte;
	logic [LEN_W-1:0]    length;
	logic [OFS_W-1:0]    offset;

	modport source (output valid, output operation, output data_byte, output length,
		output offset, input ready);
	modport sink (input valid, input operation, input data_byte, input length,
		input offset, output ready);
endinterface

interface brb_rsp_if;
	import brb_pkg::*;

	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   out_byte;
	logic [ST_W-1:0]     status;
	logic                last;
	logic [FILL_W-1:0]   fill_count;

	modport source (output valid, output out_byte, output status, output last,
		output fill_count, input ready);
	modport sink (input valid, input out_byte, input status, input last,
		input fill_count, output ready);
endinterface

`default_nettype wire

// File: rtl/byte_ring_buffer_with_peek.sv
// A write, clear or rejected request is answered in the cycle after acceptance. A read, peek
// or get of L bytes holds the request side until its last byte has left the byte store, whose
// single read port gives one byte a cycle unless the result side stalls. Where a pointer sum
// reaches twice the capacity (only after the capacity shrank) the request side also waits while
// the serial remainder unit, W bits wide (15 at DEPTH 4096), reduces it; W is the pointer width.
// Reset: asynchronous, clears pointers, fill count and burst state, capacity back to 4096.
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_peek
// Byte circular FIFO with burst writes, block read, block peek, get and clear.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_buffer_with_peek #(
	parameter int unsigned DEPTH     = brb_pkg::DEPTH_DEF,
	parameter int unsigned MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [brb_pkg::PADDR_W-1:0]   paddr,
	input  logic [brb_pkg::PDATA_W-1:0]   pwdata,
	output logic [brb_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	brb_req_if.sink                       req,
	brb_rsp_if.source                     rsp
);
	import brb_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned WW = ((CW > FILL_W) ? CW : FILL_W) + 2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOD,
		S_READ
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     held_q;
	logic [LEN_W-1:0]  brem_q;
	logic              brej_q;
	logic [AW-1:0]     idx_q;
	logic [LEN_W-1:0]  rem_q;
	logic              cons_q;
	logic              mod_wr_q;
	logic [BYTE_W-1:0] wdata_q;
	logic              rd_pend_q;
	logic              rd_last_q;
	logic [BYTE_W-1:0] rd_data_s1;

	logic              ov_q;
	logic [BYTE_W-1:0] ob_q;
	logic [ST_W-1:0]   ost_q;
	logic              olast_q;
	logic [FILL_W-1:0] ofill_q;

	logic [BYTE_W-1:0] mem [DEPTH];

	logic [CW-1:0]     cap_eff;
	logic [WW-1:0]     cap_w;
	logic [WW-1:0]     held_w;
	logic [WW-1:0]     o_w;
	logic [WW-1:0]     x;
	logic [WW-1:0]     xr;
	logic              x_fast;
	logic [LEN_W-1:0]  lsat;
	logic [LEN_W-1:0]  bl;
	logic [LEN_W-1:0]  wl;
	logic [LEN_W-1:0]  wrem;
	logic              wrej;
	logic              blk_rej;
	logic              is_wr;
	logic              is_blk;
	logic              blk_go;
	logic              acc;
	logic              out_free;
	logic              emit_acc;
	logic [ST_W-1:0]   st_acc;
	logic [CW-1:0]     fill_acc;
	logic              issue;
	logic              move;
	logic [AW-1:0]     idx_nxt;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [BYTE_W-1:0] mem_wd;
	logic              mod_start;
	logic              mod_done;
	logic [WW-1:0]     mod_r;

	brb_cfg #(.DEPTH(DEPTH)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cap_eff (cap_eff)
	);

	brb_mod #(.W(WW)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.x      (x),
		.m      (cap_w),
		.done   (mod_done),
		.r      (mod_r)
	);

	// request decode
	assign cap_w    = WW'(cap_eff);
	assign held_w   = WW'(held_q);
	assign out_free = !ov_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && !rd_pend_q && out_free;
	assign acc      = req.valid && req.ready;

	assign is_wr  = (req.operation == OP_WRITE);
	assign is_blk = (req.operation == OP_READ) || (req.operation == OP_PEEK)
		|| (req.operation == OP_GET);

	assign lsat = (req.length > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : req.length;
	assign bl   = (req.operation == OP_GET) ? LEN_W'(1) : lsat;
	assign o_w  = (req.operation == OP_PEEK) ? WW'(req.offset) : '0;

	assign blk_rej = (held_w < WW'(bl)) || ((o_w + WW'(bl)) > held_w);
	assign blk_go  = is_blk && !blk_rej && (bl != '0);

	// burst bookkeeping
	assign wl   = (brem_q != '0) ? brem_q : ((lsat == '0) ? LEN_W'(1) : lsat);
	assign wrem = wl - 1'b1;
	assign wrej = ((brem_q == '0) ? ((held_w + WW'(wl)) > cap_w) : brej_q)
		|| (held_w >= cap_w);

	// pointer sum and its fast reduction; the remainder unit covers sums of 2*capacity up
	assign x      = WW'(head_q) + (is_wr ? held_w : o_w);
	assign x_fast = x < (cap_w << 1);
	assign xr     = (x < cap_w) ? x : (x - cap_w);

	assign mod_start = acc && !x_fast && ((is_wr && !wrej) || blk_go);

	assign emit_acc = acc && !blk_go;

	always_comb begin
		st_acc   = ST_REJ;
		fill_acc = held_q;
		unique case (req.operation)
			OP_WRITE: begin
				st_acc = wrej ? ST_REJ : ST_ACK;
				if (!wrej)
					fill_acc = held_q + 1'b1;
			end
			OP_READ, OP_PEEK, OP_GET: begin
				st_acc = blk_rej ? ST_REJ : ST_ACK;
			end
			OP_CLEAR: begin
				st_acc   = ST_ACK;
				fill_acc = '0;
			end
			default: begin
				st_acc = ST_REJ;
			end
		endcase
	end

	// block streaming
	assign issue   = (state_q == S_READ) && (!rd_pend_q || out_free);
	assign move    = rd_pend_q && out_free;
	assign idx_nxt = ((WW'(idx_q) + 1'b1) == cap_w) ? '0 : (idx_q + 1'b1);

	// store write port
	assign mem_we = (acc && is_wr && !wrej && x_fast)
		|| ((state_q == S_MOD) && mod_done && mod_wr_q);
	assign mem_wa = (state_q == S_MOD) ? AW'(mod_r) : AW'(xr);
	assign mem_wd = (state_q == S_MOD) ? wdata_q : req.data_byte;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (issue)
			rd_data_s1 <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			held_q    <= '0;
			brem_q    <= '0;
			brej_q    <= 1'b0;
			idx_q     <= '0;
			rem_q     <= '0;
			cons_q    <= 1'b0;
			mod_wr_q  <= 1'b0;
			wdata_q   <= '0;
			rd_pend_q <= 1'b0;
			rd_last_q <= 1'b0;
			ov_q      <= 1'b0;
			ob_q      <= '0;
			ost_q     <= '0;
			olast_q   <= 1'b0;
			ofill_q   <= '0;
		end else begin
			if (ov_q && rsp.ready)
				ov_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (req.operation)
							OP_WRITE: begin
								brem_q <= wrem;
								brej_q <= (wrem == '0) ? 1'b0 : wrej;
								if (!wrej) begin
									held_q <= held_q + 1'b1;
									if (!x_fast) begin
										state_q  <= S_MOD;
										mod_wr_q <= 1'b1;
										wdata_q  <= req.data_byte;
									end
								end
							end
							OP_READ, OP_PEEK, OP_GET: begin
								if (blk_go) begin
									cons_q <= (req.operation != OP_PEEK);
									rem_q  <= bl;
									if (req.operation != OP_PEEK)
										held_q <= held_q - CW'(bl);
									if (x_fast) begin
										idx_q   <= AW'(xr);
										state_q <= S_READ;
									end else begin
										mod_wr_q <= 1'b0;
										state_q  <= S_MOD;
									end
								end
							end
							OP_CLEAR: begin
								head_q <= '0;
								held_q <= '0;
								brem_q <= '0;
								brej_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				S_MOD: begin
					if (mod_done) begin
						if (mod_wr_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= AW'(mod_r);
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					if (issue) begin
						rem_q     <= rem_q - 1'b1;
						rd_last_q <= (rem_q == LEN_W'(1));
						idx_q     <= idx_nxt;
						if (rem_q == LEN_W'(1)) begin
							state_q <= S_IDLE;
							if (cons_q)
								head_q <= idx_nxt;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (issue)
				rd_pend_q <= 1'b1;
			else if (move)
				rd_pend_q <= 1'b0;

			if (emit_acc) begin
				ov_q    <= 1'b1;
				ob_q    <= '0;
				ost_q   <= st_acc;
				olast_q <= 1'b1;
				ofill_q <= FILL_W'(fill_acc);
			end else if (move) begin
				ov_q    <= 1'b1;
				ob_q    <= rd_data_s1;
				ost_q   <= ST_DATA;
				olast_q <= rd_last_q;
				ofill_q <= FILL_W'(held_q);
			end
		end
	end

	assign rsp.valid      = ov_q;
	assign rsp.out_byte   = ob_q;
	assign rsp.status     = ost_q;
	assign rsp.last       = olast_q;
	assign rsp.fill_count = ofill_q;

endmodule

`default_nettype wire

// File: rtl/brb_cfg.sv
// ----------------------------------------------------------------------------
// brb_cfg
// APB register slice holding the capacity register and its clamped value.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_cfg #(
	parameter int unsigned DEPTH = brb_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [brb_pkg::PADDR_W-1:0]   paddr,
	input  logic [brb_pkg::PDATA_W-1:0]   pwdata,
	output logic [brb_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [$clog2(DEPTH+1)-1:0]    cap_eff
);
	import brb_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned MW = (CW > CAP_W) ? CW : CAP_W;

	logic [CAP_W-1:0] capacity_q;
	logic [CW-1:0]    cap_eff_q;
	logic             wr;
	logic             sel_cap;

	function automatic logic [CW-1:0] clamp_cap(input logic [CAP_W-1:0] v);
		logic [MW-1:0] e;
		e = MW'(v);
		if (e == '0)
			return CW'(1);
		if (e > MW'(DEPTH))
			return CW'(DEPTH);
		return CW'(e);
	endfunction

	assign sel_cap = (paddr[PADDR_W-1] == REG_CAPACITY);
	assign wr      = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RST;
			cap_eff_q  <= clamp_cap(CAP_RST);
		end else if (wr && sel_cap) begin
			capacity_q <= pwdata[CAP_W-1:0];
			cap_eff_q  <= clamp_cap(pwdata[CAP_W-1:0]);
		end
	end

	assign pready  = 1'b1;
	assign prdata  = sel_cap ? PDATA_W'(capacity_q) : '0;
	assign cap_eff = cap_eff_q;

endmodule

`default_nettype wire

// File: rtl/brb_mod.sv
// ----------------------------------------------------------------------------
// brb_mod
// Bit-serial remainder unit: r = x mod m, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_mod #(
	parameter int unsigned W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] x,
	input  logic [W-1:0] m,
	output logic         done,
	output logic [W-1:0] r
);
	localparam int unsigned CNW = $clog2(W);

	logic           busy_q;
	logic           done_q;
	logic [CNW-1:0] cnt_q;
	logic [W-1:0]   x_q;
	logic [W-1:0]   m_q;
	logic [W-1:0]   r_q;
	logic [W:0]     t;
	logic [W:0]     t_sub;

	assign t     = {r_q, x_q[W-1]};
	assign t_sub = t - {1'b0, m_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			m_q <= m;
			r_q <= '0;
		end else if (busy_q) begin
			x_q <= x_q << 1;
			r_q <= (t >= {1'b0, m_q}) ? t_sub[W-1:0] : t[W-1:0];
		end
	end

	assign done = done_q;
	assign r    = r_q;

endmodule

`default_nettype wire

// File: rtl/brb_chk.sv
// ----------------------------------------------------------------------------
// brb_chk
// Port-level checks on the result channel of the byte ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_chk (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          req_valid,
	input wire                          req_ready,
	input wire                          rsp_valid,
	input wire                          rsp_ready,
	input wire [brb_pkg::BYTE_W-1:0]    out_byte,
	input wire [brb_pkg::ST_W-1:0]      status,
	input wire                          last,
	input wire [brb_pkg::FILL_W-1:0]    fill_count
);
	import brb_pkg::*;

	// a stalled result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// and keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(out_byte) && $stable(status)
			&& $stable(last) && $stable(fill_count))
		else $error("result payload changed while stalled");

	// only delivered bytes carry data
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != ST_DATA) |-> (out_byte == '0) && last)
		else $error("non-data result carries a byte or is not last");

	// no new request while a block is still being delivered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last |-> !req_ready)
		else $error("request taken during block delivery");

endmodule

bind byte_ring_buffer_with_peek brb_chk u_brb_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.out_byte   (rsp.out_byte),
	.status     (rsp.status),
	.last       (rsp.last),
	.fill_count (rsp.fill_count)
);

`default_nettype wire
